// ===== rtl/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

  // Width of the duration registers; the tick counter carries one bit more.
  localparam int TICK_W = 16;
  localparam int CNT_W  = TICK_W + 1;
  localparam int LVL_W  = 8;
  localparam int FUNC_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TICK_W;

  // Bit steps of the shared multiply/divide unit: one pass for the product,
  // one for the quotient.
  localparam int MD_STEPS = 2 * LVL_W;
  localparam int MD_CNT_W = $clog2(MD_STEPS);

  localparam logic [LVL_W-1:0] LVL_FULL = {LVL_W{1'b1}};

  localparam logic [FUNC_W-1:0] FN_STEP    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TRIGGER = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RAMP    = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [7:0]        ticks_elapsed;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [1:0]       phase_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/adsr_muldiv.sv =====
`default_nettype none

// Computes floor(n * m / d) for n < d, one bit per cycle. The product is
// built by shift-and-add into {hi_r, lo_r}; the same register pair then
// performs a restoring division, shifting quotient bits into lo_r.
module adsr_muldiv (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire  [adsr_pkg::TICK_W-1:0]   op_n,
  input  wire  [adsr_pkg::LVL_W-1:0]    op_m,
  input  wire  [adsr_pkg::TICK_W-1:0]   op_d,
  output logic                          done,
  output logic [adsr_pkg::LVL_W-1:0]    quot
);

  localparam int TW = adsr_pkg::TICK_W;
  localparam int LW = adsr_pkg::LVL_W;
  localparam int CW = adsr_pkg::MD_CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(adsr_pkg::MD_STEPS - 1);
  localparam logic [CW-1:0] CNT_DIV  = CW'(LW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] hi_r;
  logic [LW-1:0] lo_r;
  logic [TW-1:0] n_r;
  logic [TW-1:0] d_r;

  logic [TW:0]   mul_sum;
  logic [TW:0]   div_trial;
  logic [TW:0]   div_diff;
  logic          div_ge;
  logic          in_div;

  assign in_div    = (cnt_r >= CNT_DIV);
  assign mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, n_r} : {(TW + 1){1'b0}});
  assign div_trial = {hi_r, lo_r[LW-1]};
  assign div_ge    = (div_trial >= {1'b0, d_r});
  assign div_diff  = div_trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= op_m;
      n_r  <= op_n;
      d_r  <= op_d;
    end else if (busy_r) begin
      if (!in_div) begin
        hi_r <= mul_sum[TW:1];
        lo_r <= {mul_sum[0], lo_r[LW-1:1]};
      end else begin
        // The partial remainder stays below d, so it fits in TW bits.
        hi_r <= div_ge ? div_diff[TW-1:0] : div_trial[TW-1:0];
        lo_r <= {lo_r[LW-2:0], div_ge};
      end
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_generator.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data   (func, ticks_elapsed)
// out_      output     out_valid / out_ready  out_data  (level, phase_out)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is in flight at a time. A trigger, a release, an unused code or a
// step while idle or in sustain goes from acceptance to the done state. A
// step that interpolates runs through evaluate and calculate: the bit-serial
// multiply/divide unit forms the product, then the quotient. A step that ends
// a ramp skips the calculate state. The next item is taken while the previous
// result waits in the output register; a stalled output holds the block in
// its final state. Reset is synchronous and needs no clearing pass.
module adsr_envelope_generator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  adsr_pkg::in_item_t            in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output adsr_pkg::out_item_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TW = adsr_pkg::TICK_W;
  localparam int CW = adsr_pkg::CNT_W;
  localparam int LW = adsr_pkg::LVL_W;

  adsr_pkg::state_t    state_r, state_nxt;
  adsr_pkg::phase_t    phase_r, phase_nxt;
  logic [CW-1:0]       tick_r, tick_nxt;
  logic [LW-1:0]       level_r, level_nxt;
  logic [LW-1:0]       rel_start_r, rel_start_nxt;
  logic [LW-1:0]       base_r, base_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  adsr_pkg::out_item_t out_data_r;

  logic [TW-1:0]       attack_r;
  logic [TW-1:0]       decay_r;
  logic [LW-1:0]       sustain_r;
  logic [TW-1:0]       release_r;

  logic [CW:0]         tick_sum;
  logic [CW-1:0]       tick_sat;
  logic [CW-1:0]       ad_sum;
  logic [CW-1:0]       x_minus_a;
  logic                out_load;

  logic                md_start;
  logic [TW-1:0]       md_n;
  logic [LW-1:0]       md_m;
  logic [TW-1:0]       md_d;
  logic                md_done;
  logic [LW-1:0]       md_quot;

  adsr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .op_n  (md_n),
    .op_m  (md_m),
    .op_d  (md_d),
    .done  (md_done),
    .quot  (md_quot)
  );

  // The count saturates instead of wrapping.
  assign tick_sum  = {1'b0, tick_r} + (CW + 1)'(in_data.ticks_elapsed);
  assign tick_sat  = tick_sum[CW] ? {CW{1'b1}} : tick_sum[CW-1:0];
  assign ad_sum    = {1'b0, attack_r} + {1'b0, decay_r};
  assign x_minus_a = tick_r - {1'b0, attack_r};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    level_nxt     = level_r;
    rel_start_nxt = rel_start_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    md_start      = 1'b0;
    md_n          = tick_r[TW-1:0];
    md_m          = adsr_pkg::LVL_FULL;
    md_d          = attack_r;

    case (state_r)
      adsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = adsr_pkg::ST_DONE;
          case (in_data.func)
            adsr_pkg::FN_TRIGGER: begin
              tick_nxt  = '0;
              phase_nxt = adsr_pkg::PH_RAMP;
            end
            adsr_pkg::FN_RELEASE: begin
              tick_nxt      = '0;
              phase_nxt     = adsr_pkg::PH_RELEASE;
              rel_start_nxt = level_r;
            end
            adsr_pkg::FN_STEP: begin
              case (phase_r)
                adsr_pkg::PH_IDLE:    level_nxt = '0;
                adsr_pkg::PH_SUSTAIN: level_nxt = sustain_r;
                default: begin
                  tick_nxt  = tick_sat;
                  state_nxt = adsr_pkg::ST_EVAL;
                end
              endcase
            end
            default: ;
          endcase
        end
      end

      adsr_pkg::ST_EVAL: begin
        state_nxt = adsr_pkg::ST_CALC;
        if (phase_r == adsr_pkg::PH_RAMP) begin
          if (tick_r >= ad_sum) begin
            level_nxt = sustain_r;
            phase_nxt = adsr_pkg::PH_SUSTAIN;
            state_nxt = adsr_pkg::ST_DONE;
          end else if (tick_r >= {1'b0, attack_r}) begin
            // Decay: 255 - (x - A) * (255 - S) / D
            md_start = 1'b1;
            md_n     = x_minus_a[TW-1:0];
            md_m     = adsr_pkg::LVL_FULL - sustain_r;
            md_d     = decay_r;
            base_nxt = adsr_pkg::LVL_FULL;
            neg_nxt  = 1'b1;
          end else begin
            md_start = 1'b1;
            base_nxt = '0;
            neg_nxt  = 1'b0;
          end
        end else begin
          if (tick_r >= {1'b0, release_r}) begin
            level_nxt = '0;
            phase_nxt = adsr_pkg::PH_IDLE;
            state_nxt = adsr_pkg::ST_DONE;
          end else begin
            md_start = 1'b1;
            md_m     = rel_start_r;
            md_d     = release_r;
            base_nxt = rel_start_r;
            neg_nxt  = 1'b1;
          end
        end
      end

      adsr_pkg::ST_CALC: begin
        if (md_done) begin
          level_nxt = neg_r ? (base_r - md_quot) : md_quot;
          state_nxt = adsr_pkg::ST_DONE;
        end
      end

      adsr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = adsr_pkg::ST_IDLE;
        end
      end

      default: state_nxt = adsr_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsr_pkg::ST_IDLE;
      phase_r     <= adsr_pkg::PH_IDLE;
      tick_r      <= '0;
      level_r     <= '0;
      rel_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      level_r     <= level_nxt;
      rel_start_r <= rel_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    neg_r  <= neg_nxt;
    if (out_load) begin
      out_data_r.level     <= level_r;
      out_data_r.phase_out <= phase_r;
    end
  end

  // Register 2 keeps only the low byte of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      sustain_r <= adsr_pkg::LVL_FULL;
      release_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        adsr_pkg::CFG_ATTACK:  attack_r  <= cfg_data[TW-1:0];
        adsr_pkg::CFG_DECAY:   decay_r   <= cfg_data[TW-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_r <= cfg_data[LW-1:0];
        adsr_pkg::CFG_RELEASE: release_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/adsr_checker.sv =====
`default_nettype none

module adsr_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire adsr_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Only one item is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  // The idle phase is only ever reached with the level at zero.
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase_out == adsr_pkg::PH_IDLE) |-> (out_data.level == '0))
    else $error("non-zero level reported in idle phase");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/adsr_envelope_generator_tb.sv =====
`default_nettype none

module adsr_envelope_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [adsr_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam longint COUNT_CEILING = (longint'(1) << adsr_pkg::CNT_W) - 1;
  localparam int ITEM_TARGET = 640;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    bit                              is_cfg;
    logic [adsr_pkg::CFG_IDX_W-1:0]  idx;
    logic [adsr_pkg::CFG_DATA_W-1:0] value;
    adsr_pkg::in_item_t              item;
    bit                              known;
    adsr_pkg::out_item_t             want;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  adsr_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  adsr_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Envelope predictor state and its copy of the registers.
  logic [adsr_pkg::TICK_W-1:0] reg_attack = '0;
  logic [adsr_pkg::TICK_W-1:0] reg_decay = '0;
  logic [adsr_pkg::LVL_W-1:0]  reg_sustain = adsr_pkg::LVL_FULL;
  logic [adsr_pkg::TICK_W-1:0] reg_release = '0;
  logic [adsr_pkg::CNT_W-1:0]  env_count = '0;
  adsr_pkg::phase_t            env_phase = adsr_pkg::PH_IDLE;
  logic [adsr_pkg::LVL_W-1:0]  env_level = '0;
  logic [adsr_pkg::LVL_W-1:0]  env_rel_start = '0;

  adsr_pkg::out_item_t awaited_results[$];
  plan_row_t           plan[$];
  int unsigned         n_sent = 0;
  int unsigned         n_errors = 0;

  adsr_envelope_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Random stalls on both sides, except for one stretch of items with none.
  function automatic bit stall_now();
    bit calm;
    calm = (n_sent >= 250) && (n_sent < 380);
    return !calm && ($urandom_range(0, 99) < 32);
  endfunction

  always @(negedge clk) begin
    out_ready <= !stall_now();
  end

  function automatic void apply_register(logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                                         logic [adsr_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      adsr_pkg::CFG_ATTACK:  reg_attack = value;
      adsr_pkg::CFG_DECAY:   reg_decay = value;
      adsr_pkg::CFG_SUSTAIN: reg_sustain = value[adsr_pkg::LVL_W-1:0];
      adsr_pkg::CFG_RELEASE: reg_release = value;
      default: ;
    endcase
  endfunction

  function automatic longint advance_count(logic [7:0] dt);
    longint x;
    x = longint'(env_count) + longint'(dt);
    if (x > COUNT_CEILING) begin
      x = COUNT_CEILING;
    end
    env_count = x[adsr_pkg::CNT_W-1:0];
    return x;
  endfunction

  function automatic adsr_pkg::out_item_t envelope_step(adsr_pkg::in_item_t it);
    longint              x;
    longint              lvl;
    adsr_pkg::out_item_t r;
    case (it.func)
      adsr_pkg::FN_TRIGGER: begin
        env_count = '0;
        env_phase = adsr_pkg::PH_RAMP;
      end
      adsr_pkg::FN_RELEASE: begin
        env_count = '0;
        env_phase = adsr_pkg::PH_RELEASE;
        env_rel_start = env_level;
      end
      adsr_pkg::FN_STEP: begin
        case (env_phase)
          adsr_pkg::PH_IDLE:    env_level = '0;
          adsr_pkg::PH_SUSTAIN: env_level = reg_sustain;
          adsr_pkg::PH_RAMP: begin
            x = advance_count(it.ticks_elapsed);
            if (x >= longint'(reg_attack) + longint'(reg_decay)) begin
              env_level = reg_sustain;
              env_phase = adsr_pkg::PH_SUSTAIN;
            end else if (x >= longint'(reg_attack)) begin
              // Signed division truncates toward zero, as the level falls.
              lvl = ((x - longint'(reg_attack)) * (longint'(reg_sustain) - 255))
                    / longint'(reg_decay) + 255;
              env_level = lvl[adsr_pkg::LVL_W-1:0];
            end else begin
              lvl = (x * 255) / longint'(reg_attack);
              env_level = lvl[adsr_pkg::LVL_W-1:0];
            end
          end
          default: begin
            x = advance_count(it.ticks_elapsed);
            if (x >= longint'(reg_release)) begin
              env_level = '0;
              env_phase = adsr_pkg::PH_IDLE;
            end else begin
              lvl = (-(x * longint'(env_rel_start))) / longint'(reg_release)
                    + longint'(env_rel_start);
              env_level = lvl[adsr_pkg::LVL_W-1:0];
            end
          end
        endcase
      end
      default: ;
    endcase
    r.level = env_level;
    r.phase_out = env_phase;
    return r;
  endfunction

  task automatic send_item(input adsr_pkg::in_item_t it, input bit known,
                           input adsr_pkg::out_item_t want);
    adsr_pkg::out_item_t predicted;
    @(negedge clk);
    while (stall_now()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    predicted = envelope_step(it);
    awaited_results.push_back(known ? want : predicted);
    n_sent++;
  endtask

  task automatic send_op(input logic [adsr_pkg::FUNC_W-1:0] func, input logic [7:0] ticks);
    adsr_pkg::in_item_t it;
    it.func = func;
    it.ticks_elapsed = ticks;
    send_item(it, 1'b0, '0);
  endtask

  // The sender holds off until every result is back and the block has settled.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adsr_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic plan_row_t item_row(logic [adsr_pkg::FUNC_W-1:0] func,
                                         logic [7:0] ticks);
    plan_row_t r;
    r = '{default: '0};
    r.item.func = func;
    r.item.ticks_elapsed = ticks;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [adsr_pkg::FUNC_W-1:0] func,
                                          logic [7:0] ticks,
                                          logic [adsr_pkg::LVL_W-1:0] lvl,
                                          adsr_pkg::phase_t ph);
    plan_row_t r;
    r = item_row(func, ticks);
    r.known = 1'b1;
    r.want.level = lvl;
    r.want.phase_out = ph;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                                        logic [adsr_pkg::CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic logic [7:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic logic [adsr_pkg::CFG_DATA_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return adsr_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      default: return adsr_pkg::CFG_DATA_W'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic logic [adsr_pkg::CFG_DATA_W-1:0] pick_sustain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return adsr_pkg::CFG_DATA_W'(adsr_pkg::LVL_FULL);
      default: return adsr_pkg::CFG_DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Occasionally slips an arbitrary transaction into a note sequence.
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      send_op(adsr_pkg::FUNC_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    adsr_pkg::out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with no expectation: level %0d, phase_out %0d",
               out_data.level, out_data.phase_out);
        n_errors++;
      end else begin
        exp_item = awaited_results.pop_front();
        if (out_data.level !== exp_item.level) begin
          $error("level: expected %0d, got %0d", exp_item.level, out_data.level);
          n_errors++;
        end
        if (out_data.phase_out !== exp_item.phase_out) begin
          $error("phase_out: expected %0d, got %0d", exp_item.phase_out,
                 out_data.phase_out);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n_steps;
    int seq;

    // With all durations zero every ramp is skipped at once.
    plan.push_back(known_row(adsr_pkg::FN_STEP, 8'd0, 8'd0, adsr_pkg::PH_IDLE));
    plan.push_back(known_row(adsr_pkg::FN_STEP, 8'd255, 8'd0, adsr_pkg::PH_IDLE));
    plan.push_back(known_row(FN_UNUSED, 8'd0, 8'd0, adsr_pkg::PH_IDLE));
    plan.push_back(known_row(adsr_pkg::FN_TRIGGER, 8'd0, 8'd0, adsr_pkg::PH_RAMP));
    plan.push_back(known_row(adsr_pkg::FN_STEP, 8'd0, 8'd255, adsr_pkg::PH_SUSTAIN));
    plan.push_back(known_row(adsr_pkg::FN_STEP, 8'd255, 8'd255, adsr_pkg::PH_SUSTAIN));
    plan.push_back(known_row(adsr_pkg::FN_RELEASE, 8'd0, 8'd255, adsr_pkg::PH_RELEASE));
    plan.push_back(known_row(adsr_pkg::FN_STEP, 8'd0, 8'd0, adsr_pkg::PH_IDLE));
    // Longest durations and the lowest sustain level.
    plan.push_back(cfg_row(adsr_pkg::CFG_ATTACK, '1));
    plan.push_back(cfg_row(adsr_pkg::CFG_DECAY, '1));
    plan.push_back(cfg_row(adsr_pkg::CFG_SUSTAIN, '0));
    plan.push_back(cfg_row(adsr_pkg::CFG_RELEASE, '1));
    plan.push_back(known_row(adsr_pkg::FN_TRIGGER, 8'd0, 8'd0, adsr_pkg::PH_RAMP));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd255));
    plan.push_back(item_row(adsr_pkg::FN_RELEASE, 8'd0));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd255));
    // Short durations: interpolation in attack, decay and release.
    plan.push_back(cfg_row(adsr_pkg::CFG_ATTACK, 16'd10));
    plan.push_back(cfg_row(adsr_pkg::CFG_DECAY, 16'd20));
    plan.push_back(cfg_row(adsr_pkg::CFG_SUSTAIN, 16'd100));
    plan.push_back(cfg_row(adsr_pkg::CFG_RELEASE, 16'd30));
    plan.push_back(item_row(adsr_pkg::FN_TRIGGER, 8'd0));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd5));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd10));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd0));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd20));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd1));
    plan.push_back(item_row(adsr_pkg::FN_TRIGGER, 8'd0));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd3));
    plan.push_back(item_row(adsr_pkg::FN_RELEASE, 8'd0));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd7));
    plan.push_back(item_row(adsr_pkg::FN_STEP, 8'd255));
    plan.push_back(item_row(FN_UNUSED, 8'd255));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].item, plan[i].known, plan[i].want);
      end
    end

    // Random note sequences: trigger, steps, usually a release, more steps.
    seq = 0;
    while (n_sent < ITEM_TARGET) begin
      if (seq % 2 == 0) begin
        drain_results();
        write_reg(adsr_pkg::CFG_ATTACK, pick_duration());
        write_reg(adsr_pkg::CFG_DECAY, pick_duration());
        write_reg(adsr_pkg::CFG_SUSTAIN, pick_sustain());
        write_reg(adsr_pkg::CFG_RELEASE, pick_duration());
      end
      maybe_noise();
      send_op(adsr_pkg::FN_TRIGGER, 8'($urandom_range(0, 255)));
      n_steps = $urandom_range(1, 16);
      repeat (n_steps) begin
        maybe_noise();
        send_op(adsr_pkg::FN_STEP, pick_ticks());
      end
      if ($urandom_range(0, 9) < 8) begin
        send_op(adsr_pkg::FN_RELEASE, 8'($urandom_range(0, 255)));
        n_steps = $urandom_range(1, 8);
        repeat (n_steps) begin
          maybe_noise();
          send_op(adsr_pkg::FN_STEP, pick_ticks());
        end
      end
      seq++;
    end

    drain_results();
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
